### src/lpht_pkg.sv
// Shared codes for the linear-probe hash table: operation and status encodings.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package lpht_pkg;

  // Operation carried on the input tuser
  typedef enum logic [1:0] {
    FN_GET = 2'd0,
    FN_SET = 2'd1,
    FN_DEL = 2'd2
  } func_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_NOT_FOUND  = 3'd0,
    ST_FOUND      = 3'd1,
    ST_INSERTED   = 3'd2,
    ST_REPLACED   = 3'd3,
    ST_DELETED    = 3'd4,
    ST_TABLE_FULL = 3'd5
  } status_t;

  // Fixed field widths of the stream payloads
  localparam int KEY_W    = 64;
  localparam int VALIN_W  = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 10;
  localparam int LIVE_W   = 11;

endpackage

### src/lpht_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### src/linear_probe_hash_table_top.sv
// Open-addressing hash table with linear probing and tombstones, keyed by a
// precomputed 64-bit hash. All slots live in one RAM entry each: used bit,
// tombstone bit, key hash and value handle. After reset the block sweeps the
// RAM once to clear every slot, with in_tready low. Each operation is then
// accepted and probed one slot a cycle, since the probe walks the single RAM
// read port, holding on the final slot until the output register is free; a
// probe visits from one slot up to CAPACITY slots. When CAPACITY is not a
// power of two, the start slot is first reduced from the hash four bits a
// cycle. A finished result waits in the output register while the next
// operation is accepted and probed.
// Depends on lpht_pkg and lpht_ram.
`timescale 1ns / 1ps

module linear_probe_hash_table_top
  import lpht_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // [63:0] khash, [95:64] value_in
  input  logic [1:0]   in_tuser,   // [1:0] func
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata   // [2:0] status, [34:3] value_out,
                                   // [44:35] slot_index, [55:45] live_count
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int EW   = 2 + KEY_W + VALUE_BITS;
  localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_MOD   = 4'b0100,
    S_PROBE = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [IW-1:0]         cur_r, cur_nxt;
  logic [IW-1:0]         vis_r, vis_nxt;
  logic [IW-1:0]         clr_r, clr_nxt;
  logic [IW-1:0]         rem_r, rem_nxt;
  logic [3:0]            dig_r, dig_nxt;
  logic [KEY_W-1:0]      sh_r, sh_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [1:0]            func_r;
  logic [KEY_W-1:0]      key_r;
  logic [VALUE_BITS-1:0] val_r;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [VALIN_W-1:0]    out_value_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [LIVE_W-1:0]     out_live_r;

  // RAM ports
  logic                  we;
  logic [IW-1:0]         waddr;
  logic [EW-1:0]         wdata;
  logic [EW-1:0]         ram_wdata;
  logic [IW-1:0]         raddr;
  logic [EW-1:0]         rd_data;

  // Decoded slot entry
  logic                  e_used;
  logic                  e_tomb;
  logic [KEY_W-1:0]      e_key;
  logic [VALUE_BITS-1:0] e_val;
  logic [63:0]           e_val64;
  logic [63:0]           in_val64;
  logic                  match;
  logic                  last_visit;
  logic [IW-1:0]         nxt_idx;

  // Start-slot reduction step
  logic [IW+3:0]         mod_x;
  logic [IW+3:0]         mod_sub;
  logic [IW-1:0]         mod_r;

  // Probe outcome
  logic                  in_fire;
  logic                  out_free;
  logic                  done;
  logic                  wr_req;
  logic                  cnt_inc;
  logic                  cnt_dec;
  logic                  out_load;
  status_t               res_status;
  logic [VALIN_W-1:0]    res_value;
  logic [IW-1:0]         res_slot;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign e_used   = rd_data[EW-1];
  assign e_tomb   = rd_data[EW-2];
  assign e_key    = rd_data[VALUE_BITS +: KEY_W];
  assign e_val    = rd_data[VALUE_BITS-1:0];
  assign e_val64  = 64'(e_val);
  assign in_val64 = 64'(in_tdata[KEY_W +: VALIN_W]);

  assign match      = (e_key == key_r);
  assign last_visit = (vis_r == LAST_IDX);
  assign nxt_idx    = (cur_r == LAST_IDX) ? '0 : cur_r + 1'b1;

  // Reduce one hash digit: remainder times 16 plus next nibble, minus the
  // largest multiple of CAPACITY that fits
  always_comb begin
    mod_x   = {rem_r, sh_r[KEY_W-1 -: 4]};
    mod_sub = '0;
    for (int k = 1; k < 16; k++) begin
      if (mod_x >= (IW+4)'(k * CAPACITY)) begin
        mod_sub = (IW+4)'(k * CAPACITY);
      end
    end
    mod_r = IW'(mod_x - mod_sub);
  end

  // Probe decision on the slot just read
  always_comb begin
    done       = 1'b0;
    wr_req     = 1'b0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    wdata      = '0;
    res_status = ST_NOT_FOUND;
    res_value  = '0;
    res_slot   = '0;
    unique case (func_r)
      FN_GET: begin
        if (!e_used) begin
          done = 1'b1;
        end else if (match) begin
          done = 1'b1;
          if (!e_tomb) begin
            res_status = ST_FOUND;
            res_value  = e_val64[VALIN_W-1:0];
            res_slot   = cur_r;
          end
        end else if (last_visit) begin
          done = 1'b1;
        end
      end
      FN_SET: begin
        if (!e_used || match) begin
          done     = 1'b1;
          wr_req   = 1'b1;
          wdata    = {1'b1, 1'b0, key_r, val_r};
          res_slot = cur_r;
          if (!e_used || e_tomb) begin
            res_status = ST_INSERTED;
            cnt_inc    = 1'b1;
          end else begin
            res_status = ST_REPLACED;
          end
        end else if (last_visit) begin
          done       = 1'b1;
          res_status = ST_TABLE_FULL;
        end
      end
      FN_DEL: begin
        if (!e_used) begin
          done = 1'b1;
        end else if (match && !e_tomb) begin
          done       = 1'b1;
          wr_req     = 1'b1;
          wdata      = {1'b1, 1'b1, key_r, e_val};
          res_status = ST_DELETED;
          res_slot   = cur_r;
          cnt_dec    = 1'b1;
        end else if (last_visit) begin
          done = 1'b1;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // Write zeros during the clear sweep, else the probe's update
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : wdata;

  // Sequencer: clear sweep, start-slot reduction, probe walk
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    vis_nxt   = vis_r;
    clr_nxt   = clr_r;
    rem_nxt   = rem_r;
    dig_nxt   = dig_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    raddr     = cur_r;
    waddr     = cur_r;
    we        = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        raddr = in_tdata[IW-1:0];
        if (in_fire) begin
          if (POW2) begin
            cur_nxt   = in_tdata[IW-1:0];
            vis_nxt   = '0;
            state_nxt = S_PROBE;
          end else begin
            sh_nxt    = in_tdata[KEY_W-1:0];
            rem_nxt   = '0;
            dig_nxt   = '0;
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        rem_nxt = mod_r;
        sh_nxt  = sh_r << 4;
        dig_nxt = dig_r + 1'b1;
        if (dig_r == 4'd15) begin
          cur_nxt   = mod_r;
          raddr     = mod_r;
          vis_nxt   = '0;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (done) begin
          // hold on the same slot until the output register is free
          if (out_free) begin
            we        = wr_req;
            out_load  = 1'b1;
            state_nxt = S_IDLE;
            if (cnt_inc) begin
              cnt_nxt = cnt_r + 1'b1;
            end else if (cnt_dec && (cnt_r != '0)) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
        end else begin
          cur_nxt = nxt_idx;
          vis_nxt = vis_r + 1'b1;
          raddr   = nxt_idx;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk and payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    vis_r <= vis_nxt;
    rem_r <= rem_nxt;
    dig_r <= dig_nxt;
    sh_r  <= sh_nxt;
    if (in_fire) begin
      func_r <= in_tuser;
      key_r  <= in_tdata[KEY_W-1:0];
      val_r  <= in_val64[VALUE_BITS-1:0];
    end
    if (out_load) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
      out_slot_r   <= SLOT_W'(res_slot);
      out_live_r   <= LIVE_W'(cnt_nxt);
    end
  end

  lpht_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (waddr),
    .wr_data (ram_wdata),
    .rd_addr (raddr),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_live_r, out_slot_r, out_value_r, out_status_r};

endmodule

### dv/tb_linear_probe_hash_table_top.sv
// Self-checking testbench for linear_probe_hash_table_top: get/set/delete streams checked
// against a behavioral copy of the probed table. Depends on lpht_pkg and the top level RTL.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table_top
  import lpht_pkg::*;
();

  localparam int          CAPACITY   = 1024;
  localparam int          TIMEOUT    = 5000000;
  localparam int          DRAIN      = 1200;
  localparam int          HOLD_LEN   = 300;
  localparam int          POOL_SIZE  = 48;
  localparam logic [1:0]  FN_UNKNOWN = 2'd3;
  localparam logic [63:0] KEY_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KEY_WRAP   = 64'd2047;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic [31:0] value;
  } op_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
    logic [9:0]  slot;
    logic [10:0] live;
  } lookup_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;   // [63:0] khash, [95:64] value_in
  logic [1:0]   in_tuser = '0;   // [1:0] func
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [55:0]  out_tdata;       // [2:0] status, [34:3] value_out,
                                 // [44:35] slot_index, [55:45] live_count

  // Shadow copy of the table
  bit          tbl_used [CAPACITY];
  bit          tbl_dead [CAPACITY];
  logic [63:0] tbl_key  [CAPACITY];
  logic [31:0] tbl_val  [CAPACITY];
  int          tbl_live;
  int          tbl_fill;

  lookup_t     lookup_results_q[$];
  logic [63:0] key_pool[POOL_SIZE];
  int          status_seen[6];
  int          ops_sent;
  int          err_cnt;
  int          cycle_cnt;
  bit          idle_on;
  bit          hold_req;

  linear_probe_hash_table_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == TIMEOUT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               lookup_results_q.size());
      $display("FAIL linear_probe_hash_table_top");
      $finish;
    end
  end

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 15))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t make_op(logic [1:0] func, logic [63:0] key, logic [31:0] value);
    op_t op;
    op.func  = func;
    op.key   = key;
    op.value = value;
    return op;
  endfunction

  // Walk the shadow table for one operation and update it
  task automatic probe_table(input op_t op, output lookup_t res);
    int unsigned idx;
    res        = '0;
    res.status = ST_NOT_FOUND;
    idx        = int'(op.key % CAPACITY);
    case (op.func)
      FN_GET: begin
        for (int n = 0; n < CAPACITY; n++) begin
          if (!tbl_used[idx]) break;
          if (tbl_key[idx] == op.key) begin
            if (!tbl_dead[idx]) begin
              res.status = ST_FOUND;
              res.value  = tbl_val[idx];
              res.slot   = idx[9:0];
            end
            break;
          end
          idx = (idx + 1) % CAPACITY;
        end
      end
      FN_SET: begin
        res.status = ST_TABLE_FULL;
        for (int n = 0; n < CAPACITY; n++) begin
          if (!tbl_used[idx]) begin
            tbl_used[idx] = 1'b1;
            tbl_dead[idx] = 1'b0;
            tbl_key[idx]  = op.key;
            tbl_val[idx]  = op.value;
            tbl_live++;
            tbl_fill++;
            res.status = ST_INSERTED;
            res.slot   = idx[9:0];
            break;
          end
          if (tbl_key[idx] == op.key) begin
            res.status    = tbl_dead[idx] ? ST_INSERTED : ST_REPLACED;
            if (tbl_dead[idx]) tbl_live++;
            tbl_dead[idx] = 1'b0;
            tbl_val[idx]  = op.value;
            res.slot      = idx[9:0];
            break;
          end
          idx = (idx + 1) % CAPACITY;
        end
      end
      FN_DEL: begin
        for (int n = 0; n < CAPACITY; n++) begin
          if (!tbl_used[idx]) break;
          if (tbl_key[idx] == op.key && !tbl_dead[idx]) begin
            tbl_dead[idx] = 1'b1;
            if (tbl_live > 0) tbl_live--;
            res.status = ST_DELETED;
            res.slot   = idx[9:0];
            break;
          end
          idx = (idx + 1) % CAPACITY;
        end
      end
      default: ;  // unknown operation leaves the table alone
    endcase
    res.live = tbl_live[10:0];
  endtask

  // Offer one operation, wait for the transfer, then queue its expected result
  task automatic send_op(input op_t op);
    lookup_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {op.value, op.key};
    in_tuser  <= op.func;
    do @(posedge clk); while (!in_tready);
    probe_table(op, res);
    lookup_results_q.push_back(res);
    status_seen[res.status]++;
    ops_sent++;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    lookup_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (lookup_results_q.size() == 0) begin
        $error("result transfer with nothing expected, status %0d", out_tdata[2:0]);
        err_cnt++;
      end else begin
        want = lookup_results_q.pop_front();
        if (out_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[2:0]);
          err_cnt++;
        end
        if (out_tdata[34:3] !== want.value) begin
          $error("value_out: expected %0h, got %0h", want.value, out_tdata[34:3]);
          err_cnt++;
        end
        if (out_tdata[44:35] !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, out_tdata[44:35]);
          err_cnt++;
        end
        if (out_tdata[55:45] !== want.live) begin
          $error("live_count: expected %0d, got %0d", want.live, out_tdata[55:45]);
          err_cnt++;
        end
      end
    end
  end

  // Empty table, wrap-around chains, tombstones and the unknown operation
  task automatic test_directed();
    send_op(make_op(FN_GET, 64'h0, 32'h0));
    send_op(make_op(FN_DEL, 64'h0, 32'hFFFF_FFFF));
    send_op(make_op(FN_SET, 64'h0, 32'h0));
    send_op(make_op(FN_SET, 64'h0, 32'hFFFF_FFFF));
    send_op(make_op(FN_GET, 64'h0, 32'h0));
    send_op(make_op(FN_SET, KEY_ONES, 32'hA5A5_A5A5));
    // same start slot as the all-ones key: chain wraps past slot 0
    send_op(make_op(FN_SET, KEY_WRAP, 32'h5A5A_5A5A));
    send_op(make_op(FN_GET, KEY_WRAP, 32'h0));
    send_op(make_op(FN_DEL, KEY_ONES, 32'h0));
    send_op(make_op(FN_GET, KEY_ONES, 32'h0));
    send_op(make_op(FN_GET, KEY_WRAP, 32'h0));
    // delete skips its own tombstone and runs off the chain
    send_op(make_op(FN_DEL, KEY_ONES, 32'h0));
    // set revives the tombstone
    send_op(make_op(FN_SET, KEY_ONES, 32'h1234_5678));
    send_op(make_op(FN_DEL, KEY_WRAP, 32'h0));
    send_op(make_op(FN_SET, KEY_WRAP, 32'h8765_4321));
    send_op(make_op(FN_UNKNOWN, 64'h0, 32'hFFFF_FFFF));
    send_op(make_op(FN_UNKNOWN, KEY_ONES, 32'h0));
    send_op(make_op(FN_GET, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0));
    send_op(make_op(FN_SET, 64'h5555_5555_5555_5555, 32'h5555_5555));
    send_op(make_op(FN_DEL, 64'h0, 32'h0));
    send_op(make_op(FN_DEL, 64'h0, 32'h0));
    send_op(make_op(FN_GET, 64'h0, 32'h0));
    send_op(make_op(FN_GET, 64'h5555_5555_5555_5555, 32'h0));
    send_op(make_op(FN_SET, 64'h8000_0000_0000_0000, 32'hAAAA_AAAA));
    send_op(make_op(FN_GET, 64'h8000_0000_0000_0000, 32'h0));
  endtask

  // Mixed traffic over a small pool of keys clustered on a few start slots
  task automatic test_random_mix(input int n_ops);
    logic [9:0]  bases[6];
    logic [63:0] key;
    logic [1:0]  func;
    int          sel;
    bases = '{10'd1022, 10'd1023, 10'd0, 10'($urandom), 10'($urandom), 10'($urandom)};
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i]      = rand_key();
      key_pool[i][9:0] = bases[i % 6];
    end
    for (int i = 0; i < n_ops; i++) begin
      key = ($urandom_range(0, 9) == 0) ? rand_key()
                                         : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      sel = $urandom_range(0, 19);
      if (sel < 8)       func = FN_SET;
      else if (sel < 14) func = FN_GET;
      else if (sel < 19) func = FN_DEL;
      else               func = FN_UNKNOWN;
      send_op(make_op(func, key, rand_value()));
    end
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++)
      send_op(make_op(2'($urandom_range(0, 2)), key_pool[$urandom_range(0, POOL_SIZE - 1)],
                      rand_value()));
    idle_on = 1'b1;
  endtask

  // Fill every slot, mostly aiming keys straight at free slots
  task automatic test_fill_table();
    logic [63:0] key;
    int unsigned start;
    int unsigned slot;
    int          sel;
    while (tbl_fill < CAPACITY) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        send_op(make_op(FN_GET, tbl_key[$urandom_range(0, CAPACITY - 1)], 32'h0));
      end else if (sel == 1) begin
        send_op(make_op(FN_DEL, key_pool[$urandom_range(0, POOL_SIZE - 1)], 32'h0));
      end else begin
        key = rand_key();
        if ($urandom_range(0, 7) != 0) begin
          start = $urandom_range(0, CAPACITY - 1);
          slot  = start;
          for (int n = 0; n < CAPACITY; n++) begin
            slot = (start + n) % CAPACITY;
            if (!tbl_used[slot]) break;
          end
          key[9:0] = slot[9:0];
        end
        send_op(make_op(FN_SET, key, rand_value()));
      end
    end
  endtask

  // Full table: misses walk all slots, sets fail unless they hit their own slot
  task automatic test_full_table(input int n_ops);
    logic [63:0] key;
    int          sel;
    for (int i = 0; i < n_ops; i++) begin
      sel = $urandom_range(0, 9);
      key = tbl_key[$urandom_range(0, CAPACITY - 1)];
      case (sel)
        0, 1:    send_op(make_op(FN_SET, rand_key(), rand_value()));
        2:       send_op(make_op(FN_GET, rand_key(), 32'h0));
        3:       send_op(make_op(FN_DEL, rand_key(), 32'h0));
        4, 5:    send_op(make_op(FN_SET, key, rand_value()));
        6, 7:    send_op(make_op(FN_DEL, key, 32'h0));
        8:       send_op(make_op(FN_GET, key, 32'h0));
        default: send_op(make_op(FN_UNKNOWN, rand_key(), rand_value()));
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      tbl_used[i] = 1'b0;
      tbl_dead[i] = 1'b0;
      tbl_key[i]  = '0;
      tbl_val[i]  = '0;
    end
    tbl_live = 0;
    tbl_fill = 0;
    idle_on  = 1'b1;
    hold_req = 1'b0;

    // Hold reset, then release
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix(500);
    test_backpressure();
    test_fill_table();
    idle_on = 1'b0;
    test_full_table(60);

    // Drop valid and drain
    in_tvalid <= 1'b0;
    while (lookup_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("ran %0d operations: found %0d, inserted %0d, replaced %0d, deleted %0d,",
             ops_sent, status_seen[ST_FOUND], status_seen[ST_INSERTED],
             status_seen[ST_REPLACED], status_seen[ST_DELETED]);
    $display("not found %0d, table full %0d, final live entries %0d, %0d errors",
             status_seen[ST_NOT_FOUND], status_seen[ST_TABLE_FULL], tbl_live, err_cnt);
    if (err_cnt == 0 && lookup_results_q.size() == 0) begin
      $display("PASS linear_probe_hash_table_top");
    end else begin
      $display("FAIL linear_probe_hash_table_top");
    end
    $finish;
  end

endmodule

### linear_probe_hash_table_top.f
src/lpht_pkg.sv
src/lpht_ram.sv
src/linear_probe_hash_table_top.sv
dv/tb_linear_probe_hash_table_top.sv
